FILE: rtl/ugcf_pkg.sv
// Shared types and constants of the uniform grid collision finder.
// Used by ugcf_ctrl, ugcf_dp and the top level; no dependencies.
package ugcf_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLS    = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_FIND   = 2'd3;

    localparam logic [2:0] KIND_ADDED   = 3'd0;
    localparam logic [2:0] KIND_OUTSIDE = 3'd1;
    localparam logic [2:0] KIND_FULL    = 3'd2;
    localparam logic [2:0] KIND_REMOVED = 3'd3;
    localparam logic [2:0] KIND_PAIR    = 3'd4;
    localparam logic [2:0] KIND_DONE    = 3'd5;

    localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] CFG_GRID_ROWS = 3'd2;
    localparam logic [2:0] CFG_GRID_COLS = 3'd3;
    localparam logic [2:0] CFG_CELL_SIZE = 3'd4;

    localparam logic [1:0] RD_A  = 2'd0;
    localparam logic [1:0] RD_B  = 2'd1;
    localparam logic [1:0] RD_RI = 2'd2;

    localparam logic [3:0] NB_LAST = 4'd8;

    typedef struct packed {
        logic       load;
        logic       clr;
        logic       loc;
        logic       div;
        logic       add;
        logic       rm_init;
        logic       rm_step;
        logic       rm_fin;
        logic       f_init;
        logic       cell_next;
        logic       nb_init;
        logic       nb_next;
        logic       a_init;
        logic       a_next;
        logic       a_take;
        logic       b_next;
        logic [1:0] rd_sel;
        logic       emit;
        logic [2:0] emit_kind;
        logic       emit_last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       bad;
        logic       div_done;
        logic       cell_bad;
        logic       full;
        logic       rm_done;
        logic       cell_end;
        logic       cur_has;
        logic       nb_ok;
        logic       nb_last;
        logic       a_ok;
        logic       a_last;
        logic       b_hit;
        logic       b_last;
        logic       out_free;
    } t_status;

    // Neighbor index: column offset outer, row offset inner, each -1..1.
    function automatic logic signed [1:0] nb_dc(input logic [3:0] nb);
        logic signed [1:0] d;
        case (nb)
            4'd0, 4'd1, 4'd2: d = -2'sd1;
            4'd3, 4'd4, 4'd5: d = 2'sd0;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] nb_dr(input logic [3:0] nb);
        logic signed [1:0] d;
        case (nb)
            4'd0, 4'd3, 4'd6: d = -2'sd1;
            4'd1, 4'd4, 4'd7: d = 2'sd0;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/uniform_grid_collision_finder_core.sv
// Uniform grid collision finder, top level: ugcf_ctrl and ugcf_dp over ugcf_pkg.
// One item at a time; the next item is taken the cycle after its final result is registered.
// Clear empties the table; add and remove first locate the item by repeated subtraction, and
// remove then compacts the table entry by entry. Find walks every cell, and for each occupied
// cell each in-bound neighbor cell, testing its entries as pairs; results wait on tready.
// Sync active-low reset empties the table, restores the default config and drops valid.
module uniform_grid_collision_finder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // obj_id, pos_x, pos_y, size_w, size_h, zero fill
    input  logic [1:0]  i_s_axis_tuser,  // op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // first_id, second_id, entity_count
    output logic [2:0]  o_m_axis_tuser,  // kind
    output logic        o_m_axis_tlast
);

    ugcf_pkg::t_cmd    cmd;
    ugcf_pkg::t_status st;
    logic              in_ready;
    logic [7:0]        first_id, second_id, entity_count;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tdata  = {entity_count, second_id, first_id};

    ugcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_op    (i_s_axis_tuser),
        .i_st       (st),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    ugcf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_s_axis_tuser),
        .i_obj_id       (i_s_axis_tdata[7:0]),
        .i_pos_x        (i_s_axis_tdata[23:8]),
        .i_pos_y        (i_s_axis_tdata[39:24]),
        .i_size_w       (i_s_axis_tdata[53:40]),
        .i_size_h       (i_s_axis_tdata[67:54]),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_kind         (o_m_axis_tuser),
        .o_first_id     (first_id),
        .o_second_id    (second_id),
        .o_entity_count (entity_count),
        .o_last         (o_m_axis_tlast)
    );

endmodule

FILE: rtl/ugcf_ctrl.sv
// Controller of the uniform grid collision finder: sequences locate, add,
// remove, clear and the find walk. Depends on ugcf_pkg.
module ugcf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_in_op,
    input  ugcf_pkg::t_status i_st,
    output logic              o_in_ready,
    output ugcf_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOC  = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_RM   = 4'd3;
    localparam logic [3:0] S_EMIT = 4'd4;
    localparam logic [3:0] S_FCEL = 4'd5;
    localparam logic [3:0] S_FNB  = 4'd6;
    localparam logic [3:0] S_FA   = 4'd7;
    localparam logic [3:0] S_FB   = 4'd8;

    logic [3:0] r_state, n_state;
    logic [2:0] r_kind, n_kind;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= ugcf_pkg::KIND_ADDED;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_in_op)
                        ugcf_pkg::OP_CLEAR: begin
                            o_cmd.clr = 1'b1;
                            n_kind    = ugcf_pkg::KIND_REMOVED;
                            n_state   = S_EMIT;
                        end
                        ugcf_pkg::OP_FIND: begin
                            o_cmd.f_init = 1'b1;
                            n_state      = S_FCEL;
                        end
                        default: n_state = S_LOC;
                    endcase
                end
            end
            S_LOC: begin
                o_cmd.loc = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (i_st.bad) begin
                    n_kind  = ugcf_pkg::KIND_OUTSIDE;
                    n_state = S_EMIT;
                end else if (!i_st.div_done) begin
                    o_cmd.div = 1'b1;
                end else if (i_st.cell_bad) begin
                    n_kind  = ugcf_pkg::KIND_OUTSIDE;
                    n_state = S_EMIT;
                end else if (i_st.op == ugcf_pkg::OP_ADD) begin
                    n_state = S_EMIT;
                    if (i_st.full) begin
                        n_kind = ugcf_pkg::KIND_FULL;
                    end else begin
                        o_cmd.add = 1'b1;
                        n_kind    = ugcf_pkg::KIND_ADDED;
                    end
                end else begin
                    o_cmd.rm_init = 1'b1;
                    n_state       = S_RM;
                end
            end
            S_RM: begin
                o_cmd.rd_sel = ugcf_pkg::RD_RI;
                if (i_st.rm_done) begin
                    o_cmd.rm_fin = 1'b1;
                    n_kind       = ugcf_pkg::KIND_REMOVED;
                    n_state      = S_EMIT;
                end else begin
                    o_cmd.rm_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = r_kind;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_FCEL: begin
                if (i_st.cell_end) begin
                    n_kind  = ugcf_pkg::KIND_DONE;
                    n_state = S_EMIT;
                end else if (i_st.cur_has) begin
                    o_cmd.nb_init = 1'b1;
                    n_state       = S_FNB;
                end else begin
                    o_cmd.cell_next = 1'b1;
                end
            end
            S_FNB: begin
                if (i_st.nb_ok) begin
                    o_cmd.a_init = 1'b1;
                    n_state      = S_FA;
                end else if (i_st.nb_last) begin
                    o_cmd.cell_next = 1'b1;
                    n_state         = S_FCEL;
                end else begin
                    o_cmd.nb_next = 1'b1;
                end
            end
            S_FA: begin
                o_cmd.rd_sel = ugcf_pkg::RD_A;
                if (i_st.a_ok) begin
                    o_cmd.a_take = 1'b1;
                    n_state      = S_FB;
                end else if (!i_st.a_last) begin
                    o_cmd.a_next = 1'b1;
                end else if (i_st.nb_last) begin
                    o_cmd.cell_next = 1'b1;
                    n_state         = S_FCEL;
                end else begin
                    o_cmd.nb_next = 1'b1;
                    n_state       = S_FNB;
                end
            end
            S_FB: begin
                o_cmd.rd_sel = ugcf_pkg::RD_B;
                // hold until the output register can take the pair
                if (!(i_st.b_hit && !i_st.out_free)) begin
                    o_cmd.emit      = i_st.b_hit;
                    o_cmd.emit_kind = ugcf_pkg::KIND_PAIR;
                    if (!i_st.b_last) begin
                        o_cmd.b_next = 1'b1;
                    end else if (!i_st.a_last) begin
                        o_cmd.a_next = 1'b1;
                        n_state      = S_FA;
                    end else if (i_st.nb_last) begin
                        o_cmd.cell_next = 1'b1;
                        n_state         = S_FCEL;
                    end else begin
                        o_cmd.nb_next = 1'b1;
                        n_state       = S_FNB;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/ugcf_dp.sv
// Datapath of the uniform grid collision finder: configuration, entry table,
// locate and divide-by-subtraction unit, find walk counters, output register.
// Depends on ugcf_pkg.
module ugcf_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_obj_id,
    input  logic [15:0]       i_pos_x,
    input  logic [15:0]       i_pos_y,
    input  logic [13:0]       i_size_w,
    input  logic [13:0]       i_size_h,
    input  ugcf_pkg::t_cmd    i_cmd,
    output ugcf_pkg::t_status o_st,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [2:0]        o_kind,
    output logic [7:0]        o_first_id,
    output logic [7:0]        o_second_id,
    output logic [7:0]        o_entity_count,
    output logic              o_last
);

    localparam int IW = ugcf_pkg::IDX_W;
    localparam int CW = ugcf_pkg::CNT_W;
    localparam int NE = ugcf_pkg::MAX_ENTRIES;

    // configuration
    logic [15:0] r_org_x, r_org_y;
    logic [4:0]  r_rows, r_cols;
    logic [10:0] r_csize;

    // latched input item
    logic [1:0]  r_op;
    logic [7:0]  r_id;
    logic [15:0] r_x, r_y;
    logic [13:0] r_w, r_h;

    // entry table
    logic [7:0]  r_obj   [NE];
    logic [7:0]  r_cell  [NE];
    logic [15:0] r_left  [NE];
    logic [15:0] r_top   [NE];
    logic [13:0] r_wid   [NE];
    logic [13:0] r_hgt   [NE];
    logic [CW-1:0] r_n;
    logic [7:0]  r_total;

    // locate
    logic        r_bad;
    logic [15:0] r_remx, r_remy;
    logic [4:0]  r_dcol, r_drow;

    // remove compaction
    logic [CW-1:0] r_ri, r_wk;

    // find walk
    logic [4:0]    r_row, r_col;
    logic [3:0]    r_nb;
    logic [CW-1:0] r_a, r_b;
    logic [7:0]    r_a_obj;
    logic [15:0]   r_a_left, r_a_top;
    logic [13:0]   r_a_wid, r_a_hgt;

    logic [4:0]  rows_eff, cols_eff;
    logic [10:0] cs_eff;
    logic [15:0] gw, gh;
    logic [16:0] rx, ry;
    logic        bad_x, bad_y;
    logic [7:0]  loc_cell, cur_cell, oth_cell;
    logic [IW-1:0] rd_idx;
    logic [7:0]  rd_obj, rd_cell;
    logic [15:0] rd_left, rd_top;
    logic [13:0] rd_wid, rd_hgt;
    logic        keep;
    logic [NE-1:0] cur_match;
    logic signed [5:0] orow, ocol;
    logic        ovl;
    logic signed [16:0] a_l, a_r, a_t, a_btm, b_l, b_r, b_t, b_btm;
    logic        out_free;
    logic [7:0]  emit_first;

    assign rows_eff = (r_rows > 5'(ugcf_pkg::MAX_ROWS)) ? 5'(ugcf_pkg::MAX_ROWS) : r_rows;
    assign cols_eff = (r_cols > 5'(ugcf_pkg::MAX_COLS)) ? 5'(ugcf_pkg::MAX_COLS) : r_cols;
    assign cs_eff   = (r_csize == 11'd0) ? 11'd1 : r_csize;
    assign gw       = 16'(cols_eff) * 16'(cs_eff);
    assign gh       = 16'(rows_eff) * 16'(cs_eff);
    assign rx       = {r_x[15], r_x} - {r_org_x[15], r_org_x};
    assign ry       = {r_y[15], r_y} - {r_org_y[15], r_org_y};
    assign bad_x    = rx[16] || (({1'b0, rx[15:0]} + {3'b0, r_w}) > {1'b0, gw});
    assign bad_y    = ry[16] || (({1'b0, ry[15:0]} + {3'b0, r_h}) > {1'b0, gh});
    assign loc_cell = {r_drow[3:0], r_dcol[3:0]};
    assign cur_cell = {r_row[3:0], r_col[3:0]};

    always_comb begin
        case (i_cmd.rd_sel)
            ugcf_pkg::RD_A: rd_idx = r_a[IW-1:0];
            ugcf_pkg::RD_B: rd_idx = r_b[IW-1:0];
            default:        rd_idx = r_ri[IW-1:0];
        endcase
    end

    assign rd_obj  = r_obj[rd_idx];
    assign rd_cell = r_cell[rd_idx];
    assign rd_left = r_left[rd_idx];
    assign rd_top  = r_top[rd_idx];
    assign rd_wid  = r_wid[rd_idx];
    assign rd_hgt  = r_hgt[rd_idx];
    assign keep    = !((rd_obj == r_id) && (rd_cell == loc_cell));

    always_comb begin
        for (int i = 0; i < NE; i++) begin
            cur_match[i] = (CW'(i) < r_n) && (r_cell[i] == cur_cell);
        end
    end

    assign orow     = $signed({1'b0, r_row}) + 6'(ugcf_pkg::nb_dr(r_nb));
    assign ocol     = $signed({1'b0, r_col}) + 6'(ugcf_pkg::nb_dc(r_nb));
    assign oth_cell = {orow[3:0], ocol[3:0]};

    assign a_l   = $signed({r_a_left[15], r_a_left});
    assign a_r   = a_l + $signed({3'b0, r_a_wid});
    assign a_t   = $signed({r_a_top[15], r_a_top});
    assign a_btm = a_t + $signed({3'b0, r_a_hgt});
    assign b_l   = $signed({rd_left[15], rd_left});
    assign b_r   = b_l + $signed({3'b0, rd_wid});
    assign b_t   = $signed({rd_top[15], rd_top});
    assign b_btm = b_t + $signed({3'b0, rd_hgt});
    assign ovl   = (a_l < b_r) && (a_r > b_l) && (a_t < b_btm) && (a_btm > b_t);

    assign out_free = !o_out_valid || i_out_ready;

    always_comb begin
        o_st          = '0;
        o_st.op       = r_op;
        o_st.bad      = r_bad;
        o_st.div_done = (r_remx < {5'b0, cs_eff}) && (r_remy < {5'b0, cs_eff});
        o_st.cell_bad = (r_drow >= rows_eff) || (r_dcol >= cols_eff);
        o_st.full     = (r_n >= CW'(NE));
        o_st.rm_done  = (r_ri >= r_n);
        o_st.cell_end = (r_row >= rows_eff) || (cols_eff == 5'd0);
        o_st.cur_has  = |cur_match;
        o_st.nb_ok    = (orow >= 6'sd0) && (orow < $signed({1'b0, rows_eff}))
                     && (ocol >= 6'sd0) && (ocol < $signed({1'b0, cols_eff}));
        o_st.nb_last  = (r_nb == ugcf_pkg::NB_LAST);
        o_st.a_ok     = (r_a < r_n) && (rd_cell == cur_cell);
        o_st.a_last   = ((r_a + CW'(1)) >= r_n);
        o_st.b_hit    = (r_b < r_n) && (rd_cell == oth_cell) && (rd_obj != r_a_obj) && ovl;
        o_st.b_last   = ((r_b + CW'(1)) >= r_n);
        o_st.out_free = out_free;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_rows  <= 5'd16;
            r_cols  <= 5'd16;
            r_csize <= 11'd32;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ugcf_pkg::CFG_ORIGIN_X:  r_org_x <= i_cfg_data;
                ugcf_pkg::CFG_ORIGIN_Y:  r_org_y <= i_cfg_data;
                ugcf_pkg::CFG_GRID_ROWS: r_rows  <= i_cfg_data[4:0];
                ugcf_pkg::CFG_GRID_COLS: r_cols  <= i_cfg_data[4:0];
                ugcf_pkg::CFG_CELL_SIZE: r_csize <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // item, locate, divide and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_id <= i_obj_id;
            r_x  <= i_pos_x;
            r_y  <= i_pos_y;
            r_w  <= i_size_w;
            r_h  <= i_size_h;
        end
        if (i_cmd.loc) begin
            r_bad  <= bad_x || bad_y;
            r_remx <= rx[15:0];
            r_remy <= ry[15:0];
            r_dcol <= '0;
            r_drow <= '0;
        end
        if (i_cmd.div) begin
            if (r_remx >= {5'b0, cs_eff}) begin
                r_remx <= r_remx - {5'b0, cs_eff};
                r_dcol <= r_dcol + 5'd1;
            end
            if (r_remy >= {5'b0, cs_eff}) begin
                r_remy <= r_remy - {5'b0, cs_eff};
                r_drow <= r_drow + 5'd1;
            end
        end
        if (i_cmd.rm_init) begin
            r_ri <= '0;
            r_wk <= '0;
        end
        if (i_cmd.rm_step) begin
            r_ri <= r_ri + CW'(1);
            if (keep) r_wk <= r_wk + CW'(1);
        end
        if (i_cmd.f_init) begin
            r_row <= '0;
            r_col <= '0;
        end
        if (i_cmd.cell_next) begin
            if ((r_col + 5'd1) >= cols_eff) begin
                r_col <= '0;
                r_row <= r_row + 5'd1;
            end else begin
                r_col <= r_col + 5'd1;
            end
        end
        if (i_cmd.nb_init) r_nb <= '0;
        if (i_cmd.nb_next) r_nb <= r_nb + 4'd1;
        if (i_cmd.a_init)  r_a  <= '0;
        if (i_cmd.a_next)  r_a  <= r_a + CW'(1);
        if (i_cmd.a_take) begin
            r_a_obj  <= rd_obj;
            r_a_left <= rd_left;
            r_a_top  <= rd_top;
            r_a_wid  <= rd_wid;
            r_a_hgt  <= rd_hgt;
            r_b      <= '0;
        end
        if (i_cmd.b_next) r_b <= r_b + CW'(1);
    end

    // entry table payload: append on add, copy down while compacting
    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_obj[r_n[IW-1:0]]  <= r_id;
            r_cell[r_n[IW-1:0]] <= loc_cell;
            r_left[r_n[IW-1:0]] <= r_x;
            r_top[r_n[IW-1:0]]  <= r_y;
            r_wid[r_n[IW-1:0]]  <= r_w;
            r_hgt[r_n[IW-1:0]]  <= r_h;
        end else if (i_cmd.rm_step && keep) begin
            r_obj[r_wk[IW-1:0]]  <= rd_obj;
            r_cell[r_wk[IW-1:0]] <= rd_cell;
            r_left[r_wk[IW-1:0]] <= rd_left;
            r_top[r_wk[IW-1:0]]  <= rd_top;
            r_wid[r_wk[IW-1:0]]  <= rd_wid;
            r_hgt[r_wk[IW-1:0]]  <= rd_hgt;
        end
    end

    // fill count and saturating entity counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n     <= '0;
            r_total <= '0;
        end else if (i_cmd.clr) begin
            r_n     <= '0;
            r_total <= '0;
        end else if (i_cmd.add) begin
            r_n <= r_n + CW'(1);
            if (r_total != 8'h7F) r_total <= r_total + 8'd1;
        end else if (i_cmd.rm_fin) begin
            r_n <= r_wk;
            if (r_total != 8'h80) r_total <= r_total - 8'd1;
        end
    end

    always_comb begin
        if (i_cmd.emit_kind == ugcf_pkg::KIND_PAIR) begin
            emit_first = r_a_obj;
        end else if (i_cmd.emit_kind == ugcf_pkg::KIND_DONE || r_op == ugcf_pkg::OP_CLEAR) begin
            emit_first = '0;
        end else begin
            emit_first = r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_kind         <= i_cmd.emit_kind;
            o_first_id     <= emit_first;
            o_second_id    <= (i_cmd.emit_kind == ugcf_pkg::KIND_PAIR) ? rd_obj : 8'd0;
            o_entity_count <= r_total;
            o_last         <= i_cmd.emit_last;
        end
    end

endmodule

FILE: verif/ugcf_checker.sv
// Checker for the uniform grid collision finder: watches the config, input and
// result channels, predicts every result and compares them. Depends on ugcf_pkg.
module ugcf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [71:0] i_in_data,
    input  logic [1:0]  i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,
    input  logic [2:0]  i_out_user,
    input  logic        i_out_last,
    output int          o_errors,
    output int          o_pending
);

    localparam int NE = ugcf_pkg::MAX_ENTRIES;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] first_id;
        logic [7:0] second_id;
        logic [7:0] count;
        logic       last;
    } t_result;

    t_result pending_results[$];

    int org_x, org_y, rows_cfg, cols_cfg, csize_cfg;
    int n_used, total;
    logic [7:0] e_id [NE];
    int e_cell [NE];
    int e_x [NE], e_y [NE], e_w [NE], e_h [NE];

    assign o_pending = pending_results.size();

    function automatic int rows_eff();
        return rows_cfg > ugcf_pkg::MAX_ROWS ? ugcf_pkg::MAX_ROWS : rows_cfg;
    endfunction
    function automatic int cols_eff();
        return cols_cfg > ugcf_pkg::MAX_COLS ? ugcf_pkg::MAX_COLS : cols_cfg;
    endfunction

    function automatic int cell_of(int x, int y, int w, int h);
        int cs, rx, ry, r, c;
        cs = (csize_cfg == 0) ? 1 : csize_cfg;
        rx = x - org_x;
        ry = y - org_y;
        if (rx < 0 || ry < 0 || rx + w > cols_eff() * cs || ry + h > rows_eff() * cs)
            return -1;
        c = rx / cs;
        r = ry / cs;
        if (r >= rows_eff() || c >= cols_eff()) return -1;
        return r * 16 + c;
    endfunction

    function automatic bit rects_overlap(int a, int b);
        return e_x[a] < e_x[b] + e_w[b] && e_x[a] + e_w[a] > e_x[b] &&
               e_y[a] < e_y[b] + e_h[b] && e_y[a] + e_h[a] > e_y[b];
    endfunction

    function automatic void push_result(logic [2:0] kind, logic [7:0] a, logic [7:0] b,
                                        logic last);
        t_result r;
        r.kind = kind;
        r.first_id = a;
        r.second_id = b;
        r.count = total[7:0];
        r.last = last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void predict_item(logic [1:0] op, logic [71:0] d);
        logic [7:0] id;
        int x, y, w, h, home, k, cnt, orow, ocol;
        id = d[7:0];
        x = int'($signed(d[23:8]));
        y = int'($signed(d[39:24]));
        w = int'(d[53:40]);
        h = int'(d[67:54]);
        case (op)
            ugcf_pkg::OP_ADD: begin
                home = cell_of(x, y, w, h);
                if (home < 0) push_result(ugcf_pkg::KIND_OUTSIDE, id, 8'd0, 1'b1);
                else if (n_used >= NE) push_result(ugcf_pkg::KIND_FULL, id, 8'd0, 1'b1);
                else begin
                    e_id[n_used] = id; e_cell[n_used] = home;
                    e_x[n_used] = x; e_y[n_used] = y; e_w[n_used] = w; e_h[n_used] = h;
                    n_used++;
                    if (total < 127) total++;
                    push_result(ugcf_pkg::KIND_ADDED, id, 8'd0, 1'b1);
                end
            end
            ugcf_pkg::OP_REMOVE: begin
                home = cell_of(x, y, w, h);
                if (home < 0) push_result(ugcf_pkg::KIND_OUTSIDE, id, 8'd0, 1'b1);
                else begin
                    k = 0;
                    for (int i = 0; i < n_used; i++) begin
                        if (e_id[i] == id && e_cell[i] == home) continue;
                        e_id[k] = e_id[i]; e_cell[k] = e_cell[i];
                        e_x[k] = e_x[i]; e_y[k] = e_y[i]; e_w[k] = e_w[i]; e_h[k] = e_h[i];
                        k++;
                    end
                    n_used = k;
                    if (total > -128) total--;
                    push_result(ugcf_pkg::KIND_REMOVED, id, 8'd0, 1'b1);
                end
            end
            ugcf_pkg::OP_CLEAR: begin
                n_used = 0;
                total = 0;
                push_result(ugcf_pkg::KIND_REMOVED, 8'd0, 8'd0, 1'b1);
            end
            default: begin
                cnt = 0;
                for (int r = 0; r < rows_eff(); r++)
                    for (int c = 0; c < cols_eff(); c++)
                        for (int dc = -1; dc <= 1; dc++)
                            for (int dr = -1; dr <= 1; dr++) begin
                                orow = r + dr;
                                ocol = c + dc;
                                if (orow < 0 || orow >= rows_eff() || ocol < 0 ||
                                    ocol >= cols_eff()) continue;
                                for (int a = 0; a < n_used; a++) begin
                                    if (e_cell[a] != r * 16 + c) continue;
                                    for (int b = 0; b < n_used; b++) begin
                                        if (e_cell[b] != orow * 16 + ocol) continue;
                                        if (e_id[a] == e_id[b] || !rects_overlap(a, b))
                                            continue;
                                        if (cnt < NE * (NE - 1)) begin
                                            push_result(ugcf_pkg::KIND_PAIR, e_id[a],
                                                        e_id[b], 1'b0);
                                            cnt++;
                                        end
                                    end
                                end
                            end
                push_result(ugcf_pkg::KIND_DONE, 8'd0, 8'd0, 1'b1);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            org_x = 0; org_y = 0; rows_cfg = 16; cols_cfg = 16; csize_cfg = 32;
            n_used = 0; total = 0;
            pending_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    ugcf_pkg::CFG_ORIGIN_X:  org_x = int'($signed(i_cfg_data));
                    ugcf_pkg::CFG_ORIGIN_Y:  org_y = int'($signed(i_cfg_data));
                    ugcf_pkg::CFG_GRID_ROWS: rows_cfg = int'(i_cfg_data[4:0]);
                    ugcf_pkg::CFG_GRID_COLS: cols_cfg = int'(i_cfg_data[4:0]);
                    ugcf_pkg::CFG_CELL_SIZE: csize_cfg = int'(i_cfg_data[10:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_item(i_in_user, i_in_data);
            if (i_out_valid && i_out_ready) begin
                got.kind = i_out_user;
                got.first_id = i_out_data[7:0];
                got.second_id = i_out_data[15:8];
                got.count = i_out_data[23:16];
                got.last = i_out_last;
                if (pending_results.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %h", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (got != want) begin
                        if (o_errors < 10)
                            $display({"mismatch: expected kind %0d ids %0d/%0d cnt %0d ",
                                      "last %0d, got kind %0d ids %0d/%0d cnt %0d last %0d"},
                                     want.kind, want.first_id, want.second_id,
                                     $signed(want.count), want.last, got.kind,
                                     got.first_id, got.second_id, $signed(got.count),
                                     got.last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: verif/tb.sv
// Testbench top for uniform_grid_collision_finder_core: drives config and items,
// stalls the result side, and reports the verdict. Depends on ugcf_pkg, ugcf_checker.
module tb;

    logic        clk, rst_n;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid, in_ready;
    logic [71:0] in_data;
    logic [1:0]  in_op;
    logic        out_valid, out_ready, out_last;
    logic [23:0] out_data;
    logic [2:0]  out_kind;
    int          errors, pending, cycles;
    bit          quiet;

    uniform_grid_collision_finder_core DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(in_valid), .o_s_axis_tready(in_ready),
        .i_s_axis_tdata(in_data), .i_s_axis_tuser(in_op),
        .o_m_axis_tvalid(out_valid), .i_m_axis_tready(out_ready),
        .o_m_axis_tdata(out_data), .o_m_axis_tuser(out_kind), .o_m_axis_tlast(out_last)
    );

    ugcf_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data), .i_in_user(in_op),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_out_user(out_kind), .i_out_last(out_last),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Timeout sized for ~330 items, each at worst a full find walk with 57 stalled results.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 4000000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver stalls in bursts.
    initial begin
        int n;
        out_ready = 0;
        forever begin
            @(negedge clk);
            if (quiet || $urandom_range(3) != 0) out_ready = 1;
            else begin
                n = $urandom_range(1, 6);
                out_ready = 0;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        cfg_index = idx;
        cfg_data = value;
        cfg_valid = 1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic set_grid(logic [15:0] ox, logic [15:0] oy, logic [4:0] r, logic [4:0] c,
                            logic [10:0] cs);
        drain();
        write_reg(ugcf_pkg::CFG_ORIGIN_X, ox);
        write_reg(ugcf_pkg::CFG_ORIGIN_Y, oy);
        write_reg(ugcf_pkg::CFG_GRID_ROWS, {11'd0, r});
        write_reg(ugcf_pkg::CFG_GRID_COLS, {11'd0, c});
        write_reg(ugcf_pkg::CFG_CELL_SIZE, {5'd0, cs});
    endtask

    task automatic send(logic [1:0] op, logic [7:0] id, logic [15:0] x, logic [15:0] y,
                        logic [13:0] w, logic [13:0] h);
        int n;
        if (!quiet && $urandom_range(3) == 0) begin
            n = $urandom_range(1, 6);
            in_valid = 0;
            repeat (n) @(negedge clk);
        end
        in_op = op;
        in_data = {4'd0, h, w, y, x, id};
        in_valid = 1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid = 0;
    endtask

    // Random ops, mostly adds and removes of in-grid rectangles, on a grid of rows x cols cells of size cs at (ox, oy).
    task automatic random_item(int ox, int oy, int r, int c, int cs);
        int sel, x, y;
        sel = $urandom_range(99);
        x = ox + int'($urandom_range(c * cs - 1));
        y = oy + int'($urandom_range(r * cs - 1));
        if (sel < 50)
            send(ugcf_pkg::OP_ADD, 8'($urandom_range(7)), x[15:0], y[15:0],
                 14'($urandom_range(2 * cs)), 14'($urandom_range(2 * cs)));
        else if (sel < 68)
            send(ugcf_pkg::OP_REMOVE, 8'($urandom_range(7)), x[15:0], y[15:0],
                 14'($urandom_range(cs)), 14'($urandom_range(cs)));
        else if (sel < 73)
            send(ugcf_pkg::OP_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom),
                 14'($urandom), 14'($urandom));
        else if (sel < 90)
            send(ugcf_pkg::OP_FIND, 8'($urandom), 16'($urandom), 16'($urandom),
                 14'($urandom), 14'($urandom));
        else
            send(2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                 14'($urandom), 14'($urandom));
    endtask

    initial begin
        rst_n = 0;
        quiet = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        in_valid = 0; in_data = 0; in_op = ugcf_pkg::OP_ADD;
        repeat (3) @(negedge clk);
        rst_n = 1;

        // Directed: default grid (512 x 512 at origin).
        send(ugcf_pkg::OP_FIND, 8'd0, 16'd0, 16'd0, 14'd0, 14'd0);
        send(ugcf_pkg::OP_ADD, 8'd1, 16'd10, 16'd10, 14'd30, 14'd30);
        send(ugcf_pkg::OP_ADD, 8'd2, 16'd35, 16'd20, 14'd20, 14'd20);
        send(ugcf_pkg::OP_ADD, 8'd2, 16'd20, 16'd25, 14'd5, 14'd5);
        send(ugcf_pkg::OP_ADD, 8'd3, 16'd40, 16'd40, 14'd0, 14'd0);
        send(ugcf_pkg::OP_ADD, 8'd255, 16'd480, 16'd480, 14'd32, 14'd32);
        send(ugcf_pkg::OP_ADD, 8'd4, 16'd500, 16'd0, 14'd13, 14'd1);
        send(ugcf_pkg::OP_ADD, 8'd5, 16'hFFFF, 16'd0, 14'd1, 14'd1);
        send(ugcf_pkg::OP_ADD, 8'd5, 16'h8000, 16'h7FFF, 14'h3FFF, 14'h3FFF);
        send(ugcf_pkg::OP_ADD, 8'd6, 16'd36, 16'd36, 14'd10, 14'd10);
        send(ugcf_pkg::OP_ADD, 8'd7, 16'd0, 16'd0, 14'd512, 14'd512);
        send(ugcf_pkg::OP_ADD, 8'd8, 16'd50, 16'd50, 14'd5, 14'd5);
        send(ugcf_pkg::OP_ADD, 8'd9, 16'd60, 16'd60, 14'd5, 14'd5);
        send(ugcf_pkg::OP_FIND, 8'd0, 16'd0, 16'd0, 14'd0, 14'd0);
        send(ugcf_pkg::OP_REMOVE, 8'd2, 16'd35, 16'd20, 14'd0, 14'd0);
        send(ugcf_pkg::OP_REMOVE, 8'd200, 16'd100, 16'd100, 14'd0, 14'd0);
        send(ugcf_pkg::OP_REMOVE, 8'd1, 16'hF000, 16'd0, 14'd0, 14'd0);
        send(ugcf_pkg::OP_FIND, 8'd0, 16'd0, 16'd0, 14'd0, 14'd0);
        send(ugcf_pkg::OP_CLEAR, 8'd0, 16'd0, 16'd0, 14'd0, 14'd0);
        // Hold until everything has come back.
        drain();
        // Drive the counter negative past its floor.
        repeat (130) send(ugcf_pkg::OP_REMOVE, 8'd9, 16'd1, 16'd1, 14'd0, 14'd0);
        send(ugcf_pkg::OP_CLEAR, 8'd0, 16'd0, 16'd0, 14'd0, 14'd0);

        // Zero rows and cols, oversize rows/cols, zero cell size.
        set_grid(16'd0, 16'd0, 5'd0, 5'd0, 11'd0);
        send(ugcf_pkg::OP_ADD, 8'd1, 16'd0, 16'd0, 14'd0, 14'd0);
        send(ugcf_pkg::OP_REMOVE, 8'd1, 16'd0, 16'd0, 14'd0, 14'd0);
        send(ugcf_pkg::OP_FIND, 8'd0, 16'd0, 16'd0, 14'd0, 14'd0);
        set_grid(16'hFFF0, 16'hFFE0, 5'd31, 5'd31, 11'd0);
        repeat (20) random_item(-16, -32, 16, 16, 1);

        set_grid(16'h8000, 16'h7000, 5'd3, 5'd4, 11'd1024);
        repeat (40) random_item(-32768, 28672, 3, 4, 1024);
        // Grid shrinks with entries left in place.
        set_grid(16'h8000, 16'h7000, 5'd1, 5'd1, 11'd1024);
        repeat (10) random_item(-32768, 28672, 1, 1, 1024);
        set_grid(16'h7FF0, 16'd100, 5'd16, 5'd1, 11'd1);
        repeat (20) random_item(32752, 100, 16, 1, 1);
        set_grid(16'd0, 16'd0, 5'd4, 5'd4, 11'd8);
        repeat (50) random_item(0, 0, 4, 4, 8);
        drain();
        quiet = 1;
        set_grid(16'hFF00, 16'hFF00, 5'd2, 5'd2, 11'd20);
        repeat (40) random_item(-256, -256, 2, 2, 20);

        drain();
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
